// ----- src/sjbr_pkg.sv -----
// Package for the Shift-JIS kana to braille ASCII translator.
// Holds the token kinds, the queue entry type and the lookup functions.
`default_nettype none
package sjbr_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  // Lookup codes for "not a joinable kana" and "not a small ya/yu/yo".
  localparam logic [2:0] JROW_NONE = 3'd7;
  localparam logic [1:0] SCOL_NONE = 2'd3;

  // One queue entry: up to two tokens whose strings go out in order.
  typedef struct packed {
    logic        has1;
    logic [15:0] tok1;   // code of first two-byte token (or single byte in low)
    logic        dbl1;   // first token is two-byte
    logic        has2;
    logic [15:0] tok2;
    logic        dbl2;
    logic        jn;     // joined token: tok1 kana, tok2 small kana
  } qent_t;

  // Two-character string: count plus chars.
  typedef struct packed {
    logic [1:0] n;
    logic [6:0] c0;
    logic [6:0] c1;
  } str_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  // Join row: 0-5 valid rows, 6 joins without entries, JROW_NONE not joinable.
  function automatic logic [2:0] join_row(input logic [15:0] c);
    case (c)
      16'h834C: return 3'd0;
      16'h834D: return 3'd1;
      16'h8356: return 3'd2;
      16'h8357: return 3'd3;
      16'h836A: return 3'd4;
      16'h8360: return 3'd5;
      16'h8374, 16'h8375, 16'h8373: return 3'd6;
      default: return JROW_NONE;
    endcase
  endfunction

  // Small ya/yu/yo column, SCOL_NONE if none.
  function automatic logic [1:0] small_col(input logic [15:0] c);
    case (c)
      16'h8383: return 2'd0;
      16'h8385: return 2'd1;
      16'h8387: return 2'd2;
      default: return SCOL_NONE;
    endcase
  endfunction

  function automatic str_t s1(input logic [7:0] a);
    return '{n: 2'd1, c0: a[6:0], c1: 7'd0};
  endfunction

  function automatic str_t s2(input logic [7:0] a, input logic [7:0] b);
    return '{n: 2'd2, c0: a[6:0], c1: b[6:0]};
  endfunction

  localparam str_t SNONE = '{n: 2'd0, c0: 7'd0, c1: 7'd0};

  function automatic str_t single_str(input logic [7:0] b);
    if (b >= "0" && b <= "9") begin
      case (b[3:0])
        4'd0: return s1("J");
        default: return s1(8'h40 + {4'd0, b[3:0]});
      endcase
    end else if (b >= "A" && b <= "Z") return s1(b);
    else if (b >= "a" && b <= "z") return s1(b - 8'd32);
    else if (b == "?") return s1("5");
    else if (b == "#") return s1("#");
    return SNONE;
  endfunction

  function automatic str_t kana_str(input logic [7:0] t);
    case (t)
      8'h41: return s1("A");  8'h43: return s1("B");  8'h45: return s1("C");
      8'h47: return s1("F");  8'h49: return s1("I");  8'h4A: return s1("*");
      8'h4B: return s2("\"", "*"); 8'h4C: return s1("<"); 8'h4D: return s2("\"", "<");
      8'h4E: return s1("%");  8'h4F: return s2("\"", "%"); 8'h50: return s1("$");
      8'h51: return s2("\"", "]"); 8'h52: return s1("["); 8'h53: return s2("\"", "[");
      8'h54: return s1(":");  8'h55: return s2("\"", ":"); 8'h56: return s1("\\");
      8'h57: return s2("\"", "\\"); 8'h58: return s1("?"); 8'h59: return s2("\"", "?");
      8'h5A: return s1("]");  8'h5B: return s2("\"", "$"); 8'h5C: return s1("W");
      8'h5D: return s2("\"", "W"); 8'h5E: return s1("O"); 8'h5F: return s2("\"", "O");
      8'h60: return s1("R");  8'h61: return s2("\"", "R"); 8'h62: return s1("1");
      8'h63: return s1("N");  8'h64: return s2("\"", "N"); 8'h65: return s1("Q");
      8'h66: return s2("\"", "Q"); 8'h67: return s1("T"); 8'h68: return s2("\"", "T");
      8'h69: return s1("K");  8'h6A: return s1("L");  8'h6B: return s1("M");
      8'h6C: return s1("P");  8'h6D: return s1("S");  8'h6E: return s1("U");
      8'h6F: return s2("\"", "U"); 8'h70: return s2(",", "U"); 8'h71: return s1("V");
      8'h72: return s2("\"", "V"); 8'h73: return s2(",", "V"); 8'h74: return s1("X");
      8'h75: return s2("\"", "X"); 8'h76: return s2(",", "X"); 8'h77: return s1("&");
      8'h78: return s2("\"", "&"); 8'h79: return s2(",", "&"); 8'h7A: return s1("!");
      8'h7B: return s2("\"", "!"); 8'h7C: return s2(",", "!"); 8'h7D: return s1("Z");
      8'h7E: return s1("(");  8'h80: return s1("Y");  8'h81: return s1("=");
      8'h82: return s1(")");  8'h84: return s1("/");  8'h86: return s1("+");
      8'h88: return s1(">");  8'h89: return s1("E");  8'h8A: return s1("H");
      8'h8B: return s1("D");  8'h8C: return s1("G");  8'h8D: return s1("J");
      8'h8F: return s1("'");  8'h92: return s1("9");  8'h93: return s1("0");
      default: return SNONE;
    endcase
  endfunction

  function automatic str_t double_str(input logic [15:0] c);
    if (c[15:8] == 8'h83) return kana_str(c[7:0]);
    if (c[15:8] == 8'h81) begin
      case (c[7:0])
        8'h41: return s1(";");
        8'h42: return s1("4");
        8'h48: return s1("5");
        8'h5B: return s1("3");
        default: return SNONE;
      endcase
    end
    return SNONE;
  endfunction

  function automatic str_t join_str(input logic [2:0] r, input logic [1:0] c);
    case ({r, c})
      {3'd0, 2'd0}: return s2("@", "*");  {3'd0, 2'd1}: return s2("@", "%");
      {3'd0, 2'd2}: return s1("[");
      {3'd1, 2'd0}: return s2("^", "*");  {3'd1, 2'd1}: return s2("^", "%");
      {3'd1, 2'd2}: return s1("[");
      {3'd2, 2'd0}: return s2("@", ":");  {3'd2, 2'd1}: return s2("@", "?");
      {3'd2, 2'd2}: return s2("@", "W");
      {3'd3, 2'd0}: return s2("^", ":");  {3'd3, 2'd1}: return s2("^", "?");
      {3'd3, 2'd2}: return s2("^", "W");
      {3'd4, 2'd0}: return s1("K");       {3'd4, 2'd1}: return s1("M");
      {3'd4, 2'd2}: return s2("@", "S");
      {3'd5, 2'd0}: return s2("@", "O");  {3'd5, 2'd1}: return s2("@", "N");
      {3'd5, 2'd2}: return s2("@", "T");
      default: return SNONE;
    endcase
  endfunction

  function automatic str_t tok_str(input logic [15:0] t, input logic d);
    return d ? double_str(t) : single_str(t[7:0]);
  endfunction

endpackage
`default_nettype wire

// ----- src/sjbr_front.sv -----
// Front part: holds lead and kana bytes and turns each byte into a queue entry.
// Depends on sjbr_pkg.
`default_nettype none
module sjbr_front import sjbr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            q_push,
  output qent_t           q_data,
  input  wire logic       q_full
);
  logic [23:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign in_stall = q_full;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] code, kana, nd;
    b = in_text_byte;
    held_nxt = 24'd0;
    cnt_nxt = 2'd0;
    q_data = '0;
    code = {held_r[7:0], b};
    kana = held_r[23:8];
    nd = held_r[15:0];
    case (cnt_r)
      2'd0: begin
        if (is_lead(b)) begin
          held_nxt = {16'd0, b}; cnt_nxt = 2'd1;
        end else begin
          q_data.has1 = 1'b1; q_data.tok1 = {8'd0, b};
        end
      end
      2'd1: begin
        if (join_row(code) != JROW_NONE) begin
          held_nxt = {8'd0, code}; cnt_nxt = 2'd2;
        end else begin
          q_data.has1 = 1'b1; q_data.tok1 = code; q_data.dbl1 = 1'b1;
        end
      end
      2'd2: begin
        if (is_lead(b)) begin
          held_nxt = {held_r[15:0], b}; cnt_nxt = 2'd3;
        end else begin
          q_data.has1 = 1'b1; q_data.tok1 = nd; q_data.dbl1 = 1'b1;
          q_data.has2 = 1'b1; q_data.tok2 = {8'd0, b};
        end
      end
      default: begin
        if (small_col(code) != SCOL_NONE) begin
          q_data.jn = 1'b1; q_data.tok1 = kana; q_data.tok2 = code;
        end else begin
          q_data.has1 = 1'b1; q_data.tok1 = kana; q_data.dbl1 = 1'b1;
          if (join_row(code) != JROW_NONE) begin
            held_nxt = {8'd0, code}; cnt_nxt = 2'd2;
          end else begin
            q_data.has2 = 1'b1; q_data.tok2 = code; q_data.dbl2 = 1'b1;
          end
        end
      end
    endcase
    if (in_end_of_text) begin
      // flush held kana into the free slot (slot 2 is free whenever kana is held)
      if (cnt_nxt == 2'd2 || cnt_nxt == 2'd3) begin
        if (q_data.has1) begin
          q_data.has2 = 1'b1; q_data.dbl2 = 1'b1;
          q_data.tok2 = (cnt_nxt == 2'd2) ? held_nxt[15:0] : held_nxt[23:8];
        end else begin
          q_data.has1 = 1'b1; q_data.dbl1 = 1'b1;
          q_data.tok1 = (cnt_nxt == 2'd2) ? held_nxt[15:0] : held_nxt[23:8];
        end
      end
      held_nxt = 24'd0;
      cnt_nxt = 2'd0;
    end
  end

  // every accepted byte pushes an entry so last_of_run is known per item
  assign q_push = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 24'd0;
      cnt_r <= 2'd0;
    end else if (q_push) begin
      held_r <= held_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- src/sjbr_queue.sv -----
// Short queue of classified entries between front and back parts.
// Depends on sjbr_pkg.
`default_nettype none
module sjbr_queue import sjbr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t wdata,
  output logic       full,
  input  wire logic  pop,
  output qent_t      rdata,
  output logic       empty
);
  qent_t mem [QDEPTH];
  logic [QAW:0] wp_r, rp_r;

  assign full  = (wp_r[QAW] != rp_r[QAW]) && (wp_r[QAW-1:0] == rp_r[QAW-1:0]);
  assign empty = (wp_r == rp_r);
  assign rdata = mem[rp_r[QAW-1:0]];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r[QAW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- src/sjbr_back.sv -----
// Back part: looks up an entry's strings, sends one char per cycle unless stalled.
// Depends on sjbr_pkg.
`default_nettype none
module sjbr_back import sjbr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire qent_t      q_data,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_braille_char,
  output logic            out_last_of_run
);
  str_t sa, sb;
  logic [6:0] ch [4];
  logic [2:0] tot;
  logic [1:0] pos_r, pos_nxt;
  logic       ov_r;
  logic [6:0] oc_r;
  logic       ol_r;
  logic       take;

  always_comb begin
    if (q_data.jn) begin
      sa = join_str(join_row(q_data.tok1), small_col(q_data.tok2));
      sb = SNONE;
    end else begin
      sa = q_data.has1 ? tok_str(q_data.tok1, q_data.dbl1) : SNONE;
      sb = q_data.has2 ? tok_str(q_data.tok2, q_data.dbl2) : SNONE;
    end
    tot = {1'b0, sa.n} + {1'b0, sb.n};
    ch[0] = (sa.n == 2'd0) ? sb.c0 : sa.c0;
    ch[1] = (sa.n == 2'd0) ? sb.c1 : (sa.n == 2'd1) ? sb.c0 : sa.c1;
    ch[2] = (sa.n == 2'd1) ? sb.c1 : sb.c0;
    ch[3] = sb.c1;
  end

  // output register free or being taken
  assign take = !ov_r || !out_stall;

  always_comb begin
    q_pop = 1'b0;
    pos_nxt = pos_r;
    if (!q_empty && take) begin
      if (tot == 3'd0 || {1'b0, pos_r} + 3'd1 >= tot) begin
        q_pop = 1'b1;
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (take) ov_r <= !q_empty && tot != 3'd0;
    end
    if (take) begin
      oc_r <= ch[pos_r];
      ol_r <= ({1'b0, pos_r} + 3'd1 >= tot);
    end
  end

  assign out_valid = ov_r;
  assign out_braille_char = oc_r;
  assign out_last_of_run = ol_r;
endmodule
`default_nettype wire

// ----- src/shift_jis_kana_to_braille_ascii.sv -----
// Shift-JIS kana to braille ASCII translator, top level.
// Throughput: one byte per cycle at the front while the queue is not full; the back
// sends one character per cycle while not stalled, up to four characters per byte.
// An accepted byte goes into the queue, then its first character into the output
// register; held lead and joinable kana bytes come out with the item completing them.
// Reset (rst_n low, synchronous) clears held bytes, queue pointers and output valid.
`default_nettype none
module shift_jis_kana_to_braille_ascii import sjbr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_braille_char,
  output logic            out_last_of_run
);
  logic  push, full, pop, empty;
  qent_t wd, rd;

  // front: hold lead bytes and joinable kana, classify each item
  sjbr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_byte, .in_end_of_text,
    .q_push(push), .q_data(wd), .q_full(full)
  );

  // queue decouples byte intake from character output
  sjbr_queue u_queue (
    .clk, .rst_n, .push, .wdata(wd), .full, .pop, .rdata(rd), .empty
  );

  // back: table lookup and one character per cycle while out_stall is low
  sjbr_back u_back (
    .clk, .rst_n, .q_data(rd), .q_empty(empty), .q_pop(pop),
    .out_valid, .out_stall, .out_braille_char, .out_last_of_run
  );
endmodule
`default_nettype wire

// ----- tb/shift_jis_kana_to_braille_ascii_tb.sv -----
// Testbench for the Shift-JIS kana to braille ASCII translator.
// Drives bytes through a queue-fed driver, predicts braille characters in-line
// and checks them in a monitor; depends on the top-level RTL only.
`default_nettype none
module shift_jis_kana_to_braille_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [6:0] braille_char;
    logic       last_of_run;
  } braille_item_t;

  // Idle phases: percent of cycles the sender idles and the receiver stalls.
  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_braille_char;
  logic       out_last_of_run;

  shift_jis_kana_to_braille_ascii DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_braille_char(out_braille_char), .out_last_of_run(out_last_of_run)
  );

  text_item_t    pending_bytes[$];
  braille_item_t expected_chars[$];
  idle_phase_t   phase;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            error_count;

  // Stall as seen at the last rising edge: if it was low, that item was taken.
  logic in_stall_q;

  // Predictor state: held bytes, newest in the low byte, and how many are held.
  logic [23:0] held_bytes;
  logic [1:0]  held_count;
  braille_item_t step_chars[$];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Translation predictor
  // ---------------------------------------------------------------------
  function automatic bit lead_byte(logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

  // Queue up to two characters of a string, never more than four per byte.
  function automatic void push_text(string s);
    braille_item_t c;
    byte           sc;
    for (int i = 0; i < s.len() && i < 2; i++) begin
      if (step_chars.size() < 4) begin
        sc = s[i];
        c.braille_char = sc[6:0];
        c.last_of_run  = 1'b0;
        step_chars.insert(step_chars.size(), c);
      end
    end
  endfunction

  function automatic void push_single(logic [7:0] b);
    string digits;
    digits = "JABCDEFGHI";
    if (b >= "0" && b <= "9") push_text(digits.substr(b - "0", b - "0"));
    else if (b >= "A" && b <= "Z") push_text(string'(b));
    else if (b >= "a" && b <= "z") push_text(string'(b - 8'd32));
    else if (b == "?") push_text("5");
    else if (b == "#") push_text("#");
  endfunction

  function automatic string katakana_text(logic [7:0] t);
    case (t)
      8'h41: return "A";    8'h43: return "B";    8'h45: return "C";
      8'h47: return "F";    8'h49: return "I";    8'h4A: return "*";
      8'h4B: return "\"*";  8'h4C: return "<";    8'h4D: return "\"<";
      8'h4E: return "%";    8'h4F: return "\"%";  8'h50: return "$";
      8'h51: return "\"]";  8'h52: return "[";    8'h53: return "\"[";
      8'h54: return ":";    8'h55: return "\":";  8'h56: return "\\";
      8'h57: return "\"\\"; 8'h58: return "?";    8'h59: return "\"?";
      8'h5A: return "]";    8'h5B: return "\"$";  8'h5C: return "W";
      8'h5D: return "\"W";  8'h5E: return "O";    8'h5F: return "\"O";
      8'h60: return "R";    8'h61: return "\"R";  8'h62: return "1";
      8'h63: return "N";    8'h64: return "\"N";  8'h65: return "Q";
      8'h66: return "\"Q";  8'h67: return "T";    8'h68: return "\"T";
      8'h69: return "K";    8'h6A: return "L";    8'h6B: return "M";
      8'h6C: return "P";    8'h6D: return "S";    8'h6E: return "U";
      8'h6F: return "\"U";  8'h70: return ",U";   8'h71: return "V";
      8'h72: return "\"V";  8'h73: return ",V";   8'h74: return "X";
      8'h75: return "\"X";  8'h76: return ",X";   8'h77: return "&";
      8'h78: return "\"&";  8'h79: return ",&";   8'h7A: return "!";
      8'h7B: return "\"!";  8'h7C: return ",!";   8'h7D: return "Z";
      8'h7E: return "(";    8'h80: return "Y";    8'h81: return "=";
      8'h82: return ")";    8'h84: return "/";    8'h86: return "+";
      8'h88: return ">";    8'h89: return "E";    8'h8A: return "H";
      8'h8B: return "D";    8'h8C: return "G";    8'h8D: return "J";
      8'h8F: return "'";    8'h92: return "9";    8'h93: return "0";
      default: return "";
    endcase
  endfunction

  function automatic void push_double(logic [15:0] code);
    if (code[15:8] == 8'h83) push_text(katakana_text(code[7:0]));
    else if (code[15:8] == 8'h81) begin
      case (code[7:0])
        8'h41: push_text(";");
        8'h42: push_text("4");
        8'h48: push_text("5");
        8'h5B: push_text("3");
        default: ;
      endcase
    end
  endfunction

  // Row of a joinable kana: 0-5 real rows, 6 joins but has no entries, -1 not joinable.
  function automatic int kana_row(logic [15:0] code);
    case (code)
      16'h834C: return 0;
      16'h834D: return 1;
      16'h8356: return 2;
      16'h8357: return 3;
      16'h836A: return 4;
      16'h8360: return 5;
      16'h8374, 16'h8375, 16'h8373: return 6;
      default: return -1;
    endcase
  endfunction

  function automatic int small_kana_col(logic [15:0] code);
    case (code)
      16'h8383: return 0;
      16'h8385: return 1;
      16'h8387: return 2;
      default: return -1;
    endcase
  endfunction

  function automatic string joined_text(int row, int col);
    string tab [6][3];
    tab = '{'{"@*", "@%", "["}, '{"^*", "^%", "["}, '{"@:", "@?", "@W"},
            '{"^:", "^?", "^W"}, '{"K", "M", "@S"}, '{"@O", "@N", "@T"}};
    return tab[row][col];
  endfunction

  function automatic void take_two_byte(logic [15:0] code);
    if (kana_row(code) >= 0) begin
      held_bytes = {8'h00, code};
      held_count = 2'd2;
    end else begin
      push_double(code);
      held_bytes = '0;
      held_count = 2'd0;
    end
  endfunction

  function automatic void take_new_byte(logic [7:0] b);
    if (lead_byte(b)) begin
      held_bytes = {16'h0000, b};
      held_count = 2'd1;
    end else begin
      push_single(b);
      held_bytes = '0;
      held_count = 2'd0;
    end
  endfunction

  // Advance the predictor by one byte and queue the characters it yields.
  function automatic void predict_braille(text_item_t it);
    logic [15:0] kana;
    logic [7:0]  lead2;
    int          row;
    int          col;
    step_chars.delete();
    case (held_count)
      2'd0: take_new_byte(it.text_byte);
      2'd1: take_two_byte({held_bytes[7:0], it.text_byte});
      2'd2: begin
        if (lead_byte(it.text_byte)) begin
          held_bytes = {held_bytes[15:0], it.text_byte};
          held_count = 2'd3;
        end else begin
          push_double(held_bytes[15:0]);
          take_new_byte(it.text_byte);
        end
      end
      default: begin
        kana  = held_bytes[23:8];
        lead2 = held_bytes[7:0];
        row   = kana_row(kana);
        col   = small_kana_col({lead2, it.text_byte});
        if (col >= 0 && row >= 0) begin
          if (row < 6) push_text(joined_text(row, col));
          held_bytes = '0;
          held_count = 2'd0;
        end else begin
          push_double(kana);
          take_two_byte({lead2, it.text_byte});
        end
      end
    endcase
    // End of text: flush a held kana, drop a dangling lead byte.
    if (it.end_of_text) begin
      if (held_count == 2'd2) push_double(held_bytes[15:0]);
      else if (held_count == 2'd3) push_double(held_bytes[23:8]);
      held_bytes = '0;
      held_count = 2'd0;
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last_of_run = 1'b1;
    foreach (step_chars[i]) expected_chars.insert(expected_chars.size(), step_chars[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b, logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    pending_bytes.insert(pending_bytes.size(), it);
  endfunction

  function automatic void add_char(logic [15:0] code, logic eot);
    add_byte(code[15:8], 1'b0);
    add_byte(code[7:0], eot);
  endfunction

  function automatic logic [15:0] pick_joinable();
    logic [15:0] codes [9];
    codes = '{16'h834C, 16'h834D, 16'h8356, 16'h8357, 16'h836A, 16'h8360,
              16'h8374, 16'h8375, 16'h8373};
    return codes[$urandom_range(8)];
  endfunction

  function automatic logic [15:0] pick_small();
    logic [15:0] codes [3];
    codes = '{16'h8383, 16'h8385, 16'h8387};
    return codes[$urandom_range(2)];
  endfunction

  function automatic logic [7:0] pick_ascii();
    case ($urandom_range(4))
      0: return 8'h30 + 8'($urandom_range(9));
      1: return 8'h41 + 8'($urandom_range(25));
      2: return 8'h61 + 8'($urandom_range(25));
      3: return ($urandom_range(1) != 0) ? 8'h3F : 8'h23;
      default: return 8'($urandom_range(8'h7F));
    endcase
  endfunction

  // Random well-formed text with joins and kana, some noise and broken sequences.
  function automatic void add_random_chunk();
    logic eot;
    eot = ($urandom_range(9) == 0);
    case ($urandom_range(9))
      0, 1, 2: begin
        add_char(pick_joinable(), 1'b0);
        add_char(pick_small(), eot);
      end
      3, 4: add_char({8'h83, 8'h40 + 8'($urandom_range(8'h56))}, eot);
      5: add_char({8'h81, 8'($urandom_range(8'h40, 8'hFC))}, eot);
      6: add_byte(pick_ascii(), eot);
      7: begin
        // Kana alone: the text ends after it, or the next chunk follows it.
        add_char(pick_joinable(), ($urandom_range(1) != 0) ? eot : 1'b1);
      end
      8: begin
        // Kana plus a lead byte, then text ends or the next chunk's first byte is the trail.
        add_char(pick_joinable(), 1'b0);
        add_byte(8'h83, ($urandom_range(2) == 0));
      end
      default: add_byte(8'($urandom_range(255)), eot);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present pending items at the falling edge, hold while stalled
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_q) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_text_byte   <= pending_bytes[0].text_byte;
        in_end_of_text <= pending_bytes[0].end_of_text;
        predict_braille(pending_bytes.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // ---------------------------------------------------------------------
  // Monitor: compare each accepted character with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    braille_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: braille_char=%h last_of_run=%b",
               out_braille_char, out_last_of_run);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_braille_char !== want.braille_char) begin
          $error("braille_char: expected %h actual %h", want.braille_char, out_braille_char);
          error_count++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b actual %b", want.last_of_run, out_last_of_run);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_valid       = 1'b0;
    in_text_byte   = 8'h00;
    in_end_of_text = 1'b0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    held_bytes     = '0;
    held_count     = 2'd0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase          = PH_FREE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: byte extremes, punctuation, joins, missing joins, end cases.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte("a", 1'b0);
    add_byte("0", 1'b0);
    add_char(16'h8141, 1'b0);
    add_char(16'h815B, 1'b0);
    add_char(16'h8370, 1'b0);          // two-character kana
    add_char(16'h834C, 1'b0);          // ki + small ya: joined
    add_char(16'h8383, 1'b0);
    add_char(16'h8374, 1'b0);          // fu + small yu: join with no entry
    add_char(16'h8385, 1'b0);
    add_char(16'h8360, 1'b0);          // chi then a single byte
    add_byte("Z", 1'b0);
    add_char(16'h8356, 1'b0);          // shi then a non-small two-byte char
    add_char(16'hFCFC, 1'b0);
    add_char(16'h836A, 1'b1);          // ni at end of text
    add_char(16'h8357, 1'b0);          // ji, lead byte, then end
    add_byte(8'hE0, 1'b1);
    add_byte(8'h9F, 1'b1);             // dangling lead byte at end
    add_char(16'h8396, 1'b1);

    // Random part across the idle phases.
    for (int p = 0; p < 4; p++) begin
      phase = idle_phase_t'(p);
      case (phase)
        PH_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        PH_SEND_IDLE:  begin send_idle_pct = 55; recv_stall_pct = 0;  end
        PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      while (pending_bytes.size() < 30) add_random_chunk();
      while (pending_bytes.size() != 0) @(posedge clk);
    end

    // Drain: wait for every character, then keep watching for strays.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- shift_jis_kana_to_braille_ascii.f -----
src/sjbr_pkg.sv
src/sjbr_front.sv
src/sjbr_queue.sv
src/sjbr_back.sv
src/shift_jis_kana_to_braille_ascii.sv
tb/shift_jis_kana_to_braille_ascii_tb.sv
